### sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// shared constants, types and cordic step functions for quaternion_to_euler
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int INPUT_BITS_DEF    = 16;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int WF          = 30;    // fraction bits of the internal format
    localparam int W           = 36;    // internal signed word
    localparam int LOCK_BITS   = 15;
    localparam int SQRT_CELLS  = 31;
    localparam int SQW         = 63;
    localparam int ROOT_BITS   = 31;
    localparam int MAG_BITS    = 31;

    localparam logic [LOCK_BITS-1:0] LOCK_THRESHOLD_RESET = 15'd32764;
    localparam logic [31:0]          HALF_TURN            = 32'h8000_0000;

    // arctangent of 2^-i, 2^32 per full turn
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic [31:0]         z;
        logic                zero;
    } t_lane;

    typedef struct packed {
        logic signed [W-1:0] hy;
        logic signed [W-1:0] hx;
        logic signed [W-1:0] by;
        logic signed [W-1:0] bx;
        logic signed [31:0]  sp;
        logic                lock;
    } t_carry;

    typedef struct packed {
        t_lane              head;
        t_lane              pitch;
        t_lane              bank;
        logic signed [31:0] sp;
        logic               lock;
    } t_cordic;

    function automatic t_lane lane_init(input logic signed [W-1:0] y,
                                        input logic signed [W-1:0] x);
        t_lane r;
        r.zero = (x == '0) && (y == '0);
        if (x[W-1]) begin
            r.x = -x;
            r.y = -y;
            r.z = HALF_TURN;
        end else begin
            r.x = x;
            r.y = y;
            r.z = '0;
        end
        return r;
    endfunction

    function automatic t_lane cordic_step(input t_lane l, input int unsigned i);
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        t_lane               r;
        dx = l.y >>> i;
        dy = l.x >>> i;
        r  = l;
        if (!l.y[W-1]) begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + ATAN_TAB[i[4:0]];
        end else begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - ATAN_TAB[i[4:0]];
        end
        return r;
    endfunction

endpackage

### sv/qte_ifs.sv
// ----------------------------------------------------------------------------
// qte channel interfaces
// quaternion input, euler result and threshold write channels
// ----------------------------------------------------------------------------
interface qte_quat_if import qte_pkg::*; #(
    parameter int INPUT_BITS = INPUT_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [INPUT_BITS-1:0] quat_w;
    logic signed [INPUT_BITS-1:0] quat_x;
    logic signed [INPUT_BITS-1:0] quat_y;
    logic signed [INPUT_BITS-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if import qte_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] heading_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] bank_angle;
    logic                         gimbal_lock;

    modport source (output valid, heading_angle, pitch_angle, bank_angle, gimbal_lock,
                    input ready);
    modport sink   (input valid, heading_angle, pitch_angle, bank_angle, gimbal_lock,
                    output ready);
endinterface

interface qte_cfg_if import qte_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [LOCK_BITS-1:0] lock_threshold;

    modport source (output valid, lock_threshold, input ready);
    modport sink   (input valid, lock_threshold, output ready);
endinterface

### sv/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// unit quaternion to heading, pitch and bank binary angles with lock detect
// ----------------------------------------------------------------------------
// i_quat carries one quaternion per beat (w, x, y, z, signed fractions);
// o_euler returns heading, pitch and bank (180 deg is the most negative code)
// and a gimbal lock flag, one result beat for every input beat, in order.
// i_cfg writes the lock threshold; it is always ready and should only be
// written while no beats are in flight.
// From input beat to result beat a beat passes through three front-end stages
// (products, sums, 1 - sp^2), 31 square root cells, one pre-rotation stage,
// the CORDIC cells and the output register.
// Throughput is one beat per cycle while o_euler does not stall; all cells advance together.
// When o_euler is stalled with a result held, the whole pipeline holds and
// i_quat.ready drops; it rises again in the cycle the result is taken.
// Reset clears every valid bit and sets the threshold to 32764.
// ----------------------------------------------------------------------------
module quaternion_to_euler import qte_pkg::*; #(
    parameter int INPUT_BITS    = INPUT_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qte_quat_if.sink  i_quat,
    qte_euler_if.source o_euler,
    qte_cfg_if.sink   i_cfg
);

    localparam int SH = 32 - ANGLE_BITS;
    localparam logic signed [32:0] RND = (SH == 0) ? 33'sd0 : (33'sd1 <<< (SH - 1));

    function automatic logic [ANGLE_BITS-1:0] rnd_angle(input logic [31:0] z);
        logic signed [32:0] t;
        t = $signed({z[31], z}) + RND;
        return t[SH +: ANGLE_BITS];
    endfunction

    logic                 en;
    logic [LOCK_BITS-1:0] r_lock_threshold;

    assign en           = !o_euler.valid || o_euler.ready;
    assign i_quat.ready = en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_threshold <= LOCK_THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            r_lock_threshold <= i_cfg.lock_threshold;
        end
    end

    // front end
    logic           sq_v   [SQRT_CELLS+1];
    logic [SQW-1:0] sq_n   [SQRT_CELLS+1];
    logic [SQW-1:0] sq_res [SQRT_CELLS+1];
    t_carry         sq_c   [SQRT_CELLS+1];

    qte_front #(.INPUT_BITS(INPUT_BITS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_quat.valid),
        .i_quat_w         (i_quat.quat_w),
        .i_quat_x         (i_quat.quat_x),
        .i_quat_y         (i_quat.quat_y),
        .i_quat_z         (i_quat.quat_z),
        .i_lock_threshold (r_lock_threshold),
        .o_valid          (sq_v[0]),
        .o_carry          (sq_c[0]),
        .o_n              (sq_n[0])
    );

    assign sq_res[0] = '0;

    // square root chain, one result digit per cell
    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        qte_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[j]),
            .i_n     (sq_n[j]),
            .i_res   (sq_res[j]),
            .i_carry (sq_c[j]),
            .o_valid (sq_v[j+1]),
            .o_n     (sq_n[j+1]),
            .o_res   (sq_res[j+1]),
            .o_carry (sq_c[j+1])
        );
    end

    // pre-rotation into the right half plane
    logic    cw_v [CORDIC_STAGES+1];
    t_cordic cw   [CORDIC_STAGES+1];
    logic    r_pre_v;
    t_cordic r_pre;
    t_cordic n_pre;
    t_carry  last_c;

    assign last_c = sq_c[SQRT_CELLS];

    always_comb begin
        n_pre.head  = lane_init(last_c.hy, last_c.hx);
        n_pre.pitch = lane_init(W'(last_c.sp),
                                W'({1'b0, sq_res[SQRT_CELLS][ROOT_BITS-1:0]}));
        n_pre.bank  = lane_init(last_c.by, last_c.bx);
        n_pre.sp    = last_c.sp;
        n_pre.lock  = last_c.lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else if (en) begin
            r_pre_v <= sq_v[SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre <= n_pre;
        end
    end

    assign cw_v[0] = r_pre_v;
    assign cw[0]   = r_pre;

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        qte_cordic_cell #(.STAGE(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cw_v[s]),
            .i_word  (cw[s]),
            .o_valid (cw_v[s+1]),
            .o_word  (cw[s+1])
        );
    end

    // output register
    t_cordic                 fin;
    logic                    r_out_v;
    logic [ANGLE_BITS-1:0]   r_head, r_pitch, r_bank;
    logic                    r_lock;
    logic [ANGLE_BITS-1:0]   n_head, n_pitch, n_bank;

    assign fin = cw[CORDIC_STAGES];

    always_comb begin
        n_head = fin.head.zero ? '0 : rnd_angle(fin.head.z);
        if (fin.lock) begin
            // pitch is sp itself, a quarter turn being one in the fraction
            n_pitch = rnd_angle(fin.sp);
            n_bank  = '0;
        end else begin
            n_pitch = fin.pitch.zero ? '0 : rnd_angle(fin.pitch.z);
            n_bank  = fin.bank.zero ? '0 : rnd_angle(fin.bank.z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= cw_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head  <= n_head;
            r_pitch <= n_pitch;
            r_bank  <= n_bank;
            r_lock  <= fin.lock;
        end
    end

    assign o_euler.valid         = r_out_v;
    assign o_euler.heading_angle = r_head;
    assign o_euler.pitch_angle   = r_pitch;
    assign o_euler.bank_angle    = r_bank;
    assign o_euler.gimbal_lock   = r_lock;

endmodule

### sv/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// quaternion products, sin-pitch saturation, lock decision and 1 - sp^2
// ----------------------------------------------------------------------------
module qte_front import qte_pkg::*; #(
    parameter int INPUT_BITS = INPUT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [INPUT_BITS-1:0] i_quat_w,
    input  logic signed [INPUT_BITS-1:0] i_quat_x,
    input  logic signed [INPUT_BITS-1:0] i_quat_y,
    input  logic signed [INPUT_BITS-1:0] i_quat_z,
    input  logic [LOCK_BITS-1:0]         i_lock_threshold,
    output logic                         o_valid,
    output t_carry                       o_carry,
    output logic [SQW-1:0]               o_n
);

    localparam int PW  = 2 * INPUT_BITS;
    localparam int FB  = 2 * (INPUT_BITS - 1);
    localparam int SHR = (FB >= WF) ? FB - WF : 0;
    localparam int SHL = (FB < WF) ? WF - FB : 0;

    localparam logic signed [W-1:0] ONE  = W'(1) <<< WF;
    localparam logic signed [W-1:0] HALF = W'(1) <<< (WF - 1);

    function automatic logic signed [W-1:0] mulq(input logic signed [INPUT_BITS-1:0] a,
                                                 input logic signed [INPUT_BITS-1:0] b);
        logic signed [PW-1:0] p;
        logic signed [63:0]   e;
        p = a * b;
        e = 64'(p);
        e = (e >>> SHR) <<< SHL;
        return e[W-1:0];
    endfunction

    logic                r_v1, r_v2, r_v3;
    logic signed [W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_carry              r_carry2, r_carry3;
    logic [MAG_BITS-1:0] r_mag;
    logic [SQW-1:0]      r_n;

    logic signed [W-1:0]  sp_raw;
    logic signed [W-1:0]  sp_sat;
    logic [MAG_BITS-1:0]  mag;
    logic                 lock;
    t_carry               n_carry2;
    logic [2*MAG_BITS-1:0] m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= mulq(i_quat_x, i_quat_x);
            r_yy <= mulq(i_quat_y, i_quat_y);
            r_zz <= mulq(i_quat_z, i_quat_z);
            r_xy <= mulq(i_quat_x, i_quat_y);
            r_xz <= mulq(i_quat_x, i_quat_z);
            r_yz <= mulq(i_quat_y, i_quat_z);
            r_wx <= mulq(i_quat_w, i_quat_x);
            r_wy <= mulq(i_quat_w, i_quat_y);
            r_wz <= mulq(i_quat_w, i_quat_z);
        end
    end

    always_comb begin
        sp_raw = -((r_yz + r_wx) <<< 1);
        if (sp_raw > ONE) begin
            sp_sat = ONE;
        end else if (sp_raw < -ONE) begin
            sp_sat = -ONE;
        end else begin
            sp_sat = sp_raw;
        end
        mag  = sp_sat[W-1] ? MAG_BITS'(-sp_sat) : MAG_BITS'(sp_sat);
        lock = mag > {1'b0, i_lock_threshold, 15'd0};

        n_carry2.sp   = sp_sat[31:0];
        n_carry2.lock = lock;
        n_carry2.by   = r_xy - r_wz;
        n_carry2.bx   = HALF - r_xx - r_zz;
        if (lock) begin
            n_carry2.hy = -r_xz - r_wy;
            n_carry2.hx = HALF - r_yy - r_zz;
        end else begin
            n_carry2.hy = r_xz - r_wy;
            n_carry2.hx = HALF - r_xx - r_yy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry2 <= n_carry2;
            r_mag    <= mag;
        end
    end

    assign m2 = {{MAG_BITS{1'b0}}, r_mag} * {{MAG_BITS{1'b0}}, r_mag};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry3 <= r_carry2;
            r_n      <= (SQW'(1) << (2 * WF)) - SQW'(m2);
        end
    end

    assign o_valid = r_v3;
    assign o_carry = r_carry3;
    assign o_n     = r_n;

endmodule

### sv/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one digit of the bitwise integer square root, carrying the angle operands
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [SQW-1:0] i_n,
    input  logic [SQW-1:0] i_res,
    input  t_carry         i_carry,
    output logic           o_valid,
    output logic [SQW-1:0] o_n,
    output logic [SQW-1:0] o_res,
    output t_carry         o_carry
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    logic           r_valid;
    logic [SQW-1:0] r_n, r_res;
    t_carry         r_carry;
    logic [SQW-1:0] trial, n_n, n_res;

    always_comb begin
        trial = i_res + BIT;
        if (i_n >= trial) begin
            n_n   = i_n - trial;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_n   = i_n;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n     <= n_n;
            r_res   <= n_res;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_res   = r_res;
    assign o_carry = r_carry;

endmodule

### sv/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring micro-rotation for the heading, pitch and bank lanes
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_cordic i_word,
    output logic    o_valid,
    output t_cordic o_word
);

    logic    r_valid;
    t_cordic r_word;
    t_cordic n_word;

    always_comb begin
        n_word       = i_word;
        n_word.head  = cordic_step(i_word.head, STAGE);
        n_word.pitch = cordic_step(i_word.pitch, STAGE);
        n_word.bank  = cordic_step(i_word.bank, STAGE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
